@@ rtl/ttok_pkg.sv @@
// ----------------------------------------------------------------------------
// ttok_pkg: shared types and constants of the text tokenizer
// Token kind codes, queue sizing and the event record passed from the
// lexer front to the emit back end.
// ----------------------------------------------------------------------------
package ttok_pkg;

  // token kind codes
  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COMMA    = 4'd4;
  localparam logic [3:0] KIND_SEMI     = 4'd5;
  localparam logic [3:0] KIND_EQUALS   = 4'd6;
  localparam logic [3:0] KIND_NAME     = 4'd7;
  localparam logic [3:0] KIND_TRUE     = 4'd8;
  localparam logic [3:0] KIND_FALSE    = 4'd9;
  localparam logic [3:0] KIND_NIL      = 4'd10;
  localparam logic [3:0] KIND_STRING   = 4'd11;
  localparam logic [3:0] KIND_NUMBER   = 4'd12;
  localparam logic [3:0] KIND_EOF      = 4'd13;

  // event queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // all token events caused by one input item
  typedef struct packed {
    logic        two;      // second event present
    logic [3:0]  kind0;
    logic [7:0]  len0;
    logic [3:0]  kind1;
    logic [7:0]  len1;
    logic [15:0] line;     // shared by both events
  } tok_rec_t;

  // front to queue write port
  typedef struct packed {
    logic     push;
    tok_rec_t rec;
  } tok_push_t;

  // queue to back read port
  typedef struct packed {
    logic     empty;
    tok_rec_t head;
  } tok_head_t;

endpackage

@@ rtl/ttok_front.sv @@
// ----------------------------------------------------------------------------
// ttok_front: lexer front end
// Accepts one byte or end mark per item, updates the lexer mode, token
// length, keyword mask and line counter, and writes the token events of
// the item into the event queue.
// ----------------------------------------------------------------------------
module ttok_front #(
  parameter int LINE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               end_of_input,
  input  logic               q_full,
  output logic               in_stall,
  output ttok_pkg::tok_push_t wr
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_NAME = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_STR  = 3'd3,
    MODE_DASH = 3'd4,
    MODE_CMT  = 3'd5
  } mode_t;

  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  mode_t                mode, mode_next;
  logic [7:0]           token_len, token_len_next;
  logic [2:0]           kw_mask, kw_mask_next;
  logic [LINE_BITS-1:0] line_count, line_count_next, line_inc;
  logic                 accept;

  // idle-mode handling of the current byte
  mode_t      idle_mode;
  logic [7:0] idle_len;
  logic [2:0] idle_mask;
  logic       idle_emit;
  logic [3:0] idle_kind;

  // event ahead of the idle handling, and the event after it
  logic       pre_v, post_v;
  logic [3:0] pre_kind, post_kind;
  logic [7:0] pre_len, post_len, len_sat;
  logic       is_alpha, is_digit;
  logic [LINE_BITS-1:0] rec_line;

  // keyword candidates still matching after one more letter
  function automatic logic [2:0] mask_step(input logic [2:0] m, input logic [7:0] l,
                                           input logic [7:0] c);
    logic hit_t, hit_f, hit_n;
    hit_t = (l == 8'd0 && c == "t") || (l == 8'd1 && c == "r") ||
            (l == 8'd2 && c == "u") || (l == 8'd3 && c == "e");
    hit_f = (l == 8'd0 && c == "f") || (l == 8'd1 && c == "a") ||
            (l == 8'd2 && c == "l") || (l == 8'd3 && c == "s") ||
            (l == 8'd4 && c == "e");
    hit_n = (l == 8'd0 && c == "n") || (l == 8'd1 && c == "i") ||
            (l == 8'd2 && c == "l");
    return m & {hit_n, hit_f, hit_t};
  endfunction

  // kind of a finished name
  function automatic logic [3:0] name_kind(input logic [2:0] m, input logic [7:0] l);
    logic [3:0] k;
    k = ttok_pkg::KIND_NAME;
    if (m[0] && l == 8'd4) begin
      k = ttok_pkg::KIND_TRUE;
    end else if (m[1] && l == 8'd5) begin
      k = ttok_pkg::KIND_FALSE;
    end else if (m[2] && l == 8'd3) begin
      k = ttok_pkg::KIND_NIL;
    end
    return k;
  endfunction

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;
  assign is_alpha = (in_byte >= "a" && in_byte <= "z") || (in_byte >= "A" && in_byte <= "Z");
  assign is_digit = in_byte >= "0" && in_byte <= "9";
  assign len_sat  = (token_len == 8'hFF) ? token_len : token_len + 8'd1;
  assign line_inc = (in_byte == 8'h0A && line_count != LINE_MAX) ?
                    line_count + 1'b1 : line_count;

  // start of a token from idle
  always_comb begin
    idle_mode = MODE_IDLE;
    idle_len  = 8'd0;
    idle_mask = 3'b111;
    idle_emit = 1'b0;
    idle_kind = ttok_pkg::KIND_LBRACE;
    if (is_alpha) begin
      idle_mode = MODE_NAME;
      idle_len  = 8'd1;
      idle_mask = mask_step(3'b111, 8'd0, in_byte);
    end else if (is_digit) begin
      idle_mode = MODE_NUM;
      idle_len  = 8'd1;
    end else if (in_byte == "\"") begin
      idle_mode = MODE_STR;
      idle_len  = 8'd1;
    end else if (in_byte == "-") begin
      idle_mode = MODE_DASH;
    end else begin
      idle_emit = 1'b1;
      case (in_byte)
        "{":     idle_kind = ttok_pkg::KIND_LBRACE;
        "}":     idle_kind = ttok_pkg::KIND_RBRACE;
        "[":     idle_kind = ttok_pkg::KIND_LBRACKET;
        "]":     idle_kind = ttok_pkg::KIND_RBRACKET;
        ",":     idle_kind = ttok_pkg::KIND_COMMA;
        ";":     idle_kind = ttok_pkg::KIND_SEMI;
        "=":     idle_kind = ttok_pkg::KIND_EQUALS;
        default: idle_emit = 1'b0;
      endcase
    end
  end

  // mode update and event selection
  always_comb begin
    mode_next       = mode;
    token_len_next  = token_len;
    kw_mask_next    = kw_mask;
    line_count_next = line_inc;
    rec_line        = line_inc;
    pre_v           = 1'b0;
    pre_kind        = ttok_pkg::KIND_NAME;
    pre_len         = token_len;
    post_v          = 1'b0;
    post_kind       = idle_kind;
    post_len        = 8'd1;
    if (end_of_input) begin
      rec_line        = line_count;
      line_count_next = '0;
      mode_next       = MODE_IDLE;
      token_len_next  = 8'd0;
      kw_mask_next    = 3'b111;
      pre_v           = (mode == MODE_NAME) || (mode == MODE_NUM);
      pre_kind        = (mode == MODE_NAME) ? name_kind(kw_mask, token_len) :
                                              ttok_pkg::KIND_NUMBER;
      post_v          = 1'b1;
      post_kind       = ttok_pkg::KIND_EOF;
      post_len        = 8'd0;
    end else begin
      unique case (mode)
        MODE_NAME: begin
          if (is_alpha) begin
            kw_mask_next   = mask_step(kw_mask, token_len, in_byte);
            token_len_next = len_sat;
          end else begin
            pre_v          = 1'b1;
            pre_kind       = name_kind(kw_mask, token_len);
            mode_next      = idle_mode;
            token_len_next = idle_len;
            kw_mask_next   = idle_mask;
            post_v         = idle_emit;
          end
        end
        MODE_NUM: begin
          if (is_digit) begin
            token_len_next = len_sat;
          end else begin
            pre_v          = 1'b1;
            pre_kind       = ttok_pkg::KIND_NUMBER;
            mode_next      = idle_mode;
            token_len_next = idle_len;
            kw_mask_next   = idle_mask;
            post_v         = idle_emit;
          end
        end
        MODE_STR: begin
          token_len_next = len_sat;
          if (in_byte == "\"") begin
            pre_v          = 1'b1;
            pre_kind       = ttok_pkg::KIND_STRING;
            pre_len        = len_sat;
            mode_next      = MODE_IDLE;
            token_len_next = 8'd0;
            kw_mask_next   = 3'b111;
          end
        end
        MODE_DASH: begin
          if (in_byte == "-") begin
            mode_next = MODE_CMT;
          end else begin
            mode_next      = idle_mode;
            token_len_next = idle_len;
            kw_mask_next   = idle_mask;
            post_v         = idle_emit;
          end
        end
        MODE_CMT: begin
          if (in_byte == 8'h0A) begin
            mode_next      = MODE_IDLE;
            token_len_next = 8'd0;
            kw_mask_next   = 3'b111;
          end
        end
        default: begin
          mode_next      = idle_mode;
          token_len_next = idle_len;
          kw_mask_next   = idle_mask;
          post_v         = idle_emit;
        end
      endcase
    end
  end

  // pack the events of this item into one queue record
  always_comb begin
    wr.push      = accept && (pre_v || post_v);
    wr.rec.two   = pre_v && post_v;
    wr.rec.kind0 = pre_v ? pre_kind : post_kind;
    wr.rec.len0  = pre_v ? pre_len : post_len;
    wr.rec.kind1 = post_kind;
    wr.rec.len1  = post_len;
    wr.rec.line  = (32'(rec_line) > 32'h0000_FFFF) ? 16'hFFFF : 16'(rec_line);
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      token_len  <= 8'd0;
      kw_mask    <= 3'b111;
      line_count <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      token_len  <= token_len_next;
      kw_mask    <= kw_mask_next;
      line_count <= line_count_next;
    end
  end

  // end mark returns the lexer to its reset state
  a_eoi_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_input |=> line_count == '0 && mode == MODE_IDLE && kw_mask == 3'b111)
    else $error("lexer state not cleared after end mark");

endmodule

@@ rtl/ttok_fifo.sv @@
// ----------------------------------------------------------------------------
// ttok_fifo: token event queue
// Short first-in first-out store of event records between the lexer front
// and the emit back end.
// ----------------------------------------------------------------------------
module ttok_fifo (
  input  logic                clk,
  input  logic                rst,
  input  ttok_pkg::tok_push_t wr,
  input  logic                pop,
  output logic                full,
  output ttok_pkg::tok_head_t rd
);

  localparam logic [ttok_pkg::QPTR_W-1:0] PTR_LAST = ttok_pkg::QPTR_W'(ttok_pkg::QUEUE_DEPTH - 1);
  localparam logic [ttok_pkg::QCNT_W-1:0] CNT_FULL = ttok_pkg::QCNT_W'(ttok_pkg::QUEUE_DEPTH);

  ttok_pkg::tok_rec_t             mem [ttok_pkg::QUEUE_DEPTH];
  logic [ttok_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [ttok_pkg::QCNT_W-1:0]    count;

  assign full     = count == CNT_FULL;
  assign rd.empty = count == '0;
  assign rd.head  = mem[rd_ptr];

  // record storage
  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !wr.push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr.push |-> !full)
    else $error("event queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !rd.empty)
    else $error("event queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("event queue count out of range");

endmodule

@@ rtl/ttok_back.sv @@
// ----------------------------------------------------------------------------
// ttok_back: token emit back end
// Takes event records from the queue and presents their events one at a
// time in the output register, marking the final event of each item.
// ----------------------------------------------------------------------------
module ttok_back (
  input  logic                clk,
  input  logic                rst,
  input  ttok_pkg::tok_head_t rd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          token_kind,
  output logic [15:0]         token_line,
  output logic [7:0]          token_length,
  output logic                last
);

  logic second;   // first event of the head record already sent
  logic load;

  assign load = (!out_valid || !out_stall) && !rd.empty;
  assign pop  = load && (second || !rd.head.two);

  // control: output valid and event position in the record
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second    <= !second && rd.head.two;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      token_kind   <= second ? rd.head.kind1 : rd.head.kind0;
      token_length <= second ? rd.head.len1 : rd.head.len0;
      token_line   <= rd.head.line;
      last         <= second || !rd.head.two;
    end
  end

  a_second_has_head: assert property (@(posedge clk) disable iff (rst)
    second |-> !rd.empty && rd.head.two)
    else $error("second event pending without a two-event record");
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && second == 1'b0)
    else $error("second event of an item did not follow the first");

endmodule

@@ rtl/text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// text_tokenizer: byte-serial lexer for a small data language
//
// Input channel (in_valid / in_stall): one item per cycle, either a text
// byte (in_byte) or an end mark (end_of_input = 1, in_byte ignored).
// Output channel (out_valid / out_stall): token events with kind, line
// number (saturated at 65535) and length (saturated at 255). An item causes
// zero, one or two events; last marks the final event of an item.
// Events enter the queue as their item is accepted, then the output
// register; an item's second event directly follows its first. Throughput:
// one item per cycle while the queue has room, one event per cycle out
// while out_stall is low; the output register sets the event rate, and a
// four-record queue between lexer and output absorbs two-event items.
// Stall: while out_stall holds, the output register keeps its event and the
// queue fills; in_stall rises when the queue is full and falls as soon as a
// record leaves it.
// Reset: the lexer returns to idle, the line counter to zero, the queue is
// emptied and out_valid drops. The end mark also clears all lexer state.
// ----------------------------------------------------------------------------
module text_tokenizer #(
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [15:0] token_line,
  output logic [7:0]  token_length,
  output logic        last
);

  ttok_pkg::tok_push_t wr;
  ttok_pkg::tok_head_t rd;
  logic                q_full;
  logic                pop;

  // lexer front
  ttok_front #(
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .q_full       (q_full),
    .in_stall     (in_stall),
    .wr           (wr)
  );

  // event queue
  ttok_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .full (q_full),
    .rd   (rd)
  );

  // emit back end
  ttok_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rd           (rd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_line   (token_line),
    .token_length (token_length),
    .last         (last)
  );

endmodule

@@ tb/text_tokenizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_tokenizer_tb: self-checking testbench for the text tokenizer
// Feeds byte streams and end marks into the lexer, predicts each token
// event in a behavioral lexer, and checks kind, line, length and last of
// every event that leaves the block. Random idling on both channels, one
// long receiver hold-off, long tokens and line counting across end marks.
// ----------------------------------------------------------------------------
module text_tokenizer_tb;

  localparam int CYCLE_LIMIT = 1_000_000;

  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_DASH     = "-";
  localparam logic [7:0] CH_LBRACE   = "{";
  localparam logic [7:0] CH_RBRACE   = "}";
  localparam logic [7:0] CH_LBRACKET = "[";
  localparam logic [7:0] CH_RBRACKET = "]";
  localparam logic [7:0] CH_COMMA    = ",";
  localparam logic [7:0] CH_SEMI     = ";";
  localparam logic [7:0] CH_EQUALS   = "=";

  typedef enum logic [2:0] {
    PM_IDLE, PM_WORD, PM_DIGITS, PM_QUOTED, PM_DASH, PM_COMMENT
  } pred_mode_t;

  typedef struct {
    logic [3:0]  kind;
    logic [15:0] line;
    logic [7:0]  length;
    logic        last;
  } tok_event_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  token_kind;
  logic [15:0] token_line;
  logic [7:0]  token_length;
  logic        last;

  // lexer state of the predictor
  pred_mode_t  mode;
  logic [7:0]  tok_len;
  logic [2:0]  kw_mask;
  logic [15:0] line_cnt;

  tok_event_t  expected_tokens[$];
  int          items_sent = 0;
  int          tokens_checked = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  bit          idle_on = 1'b1;

  text_tokenizer uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_line   (token_line),
    .token_length (token_length),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic string keyword_text(int k);
    case (k)
      0: return "true";
      1: return "false";
      default: return "nil";
    endcase
  endfunction

  function automatic logic [3:0] keyword_kind(int k);
    case (k)
      0: return ttok_pkg::KIND_TRUE;
      1: return ttok_pkg::KIND_FALSE;
      default: return ttok_pkg::KIND_NIL;
    endcase
  endfunction

  function automatic void push_token(logic [3:0] kind, logic [7:0] length);
    tok_event_t ev;
    ev.kind   = kind;
    ev.line   = line_cnt;
    ev.length = length;
    ev.last   = 1'b0;
    expected_tokens.push_back(ev);
  endfunction

  function automatic void lex_go_idle();
    mode    = PM_IDLE;
    tok_len = 8'd0;
    kw_mask = 3'b111;
  endfunction

  // length saturates at 255
  function automatic void tok_len_step();
    if (tok_len != 8'hFF) tok_len++;
  endfunction

  // drop every keyword that the new letter rules out
  function automatic void name_push_char(logic [7:0] c);
    string w;
    for (int k = 0; k < 3; k++) begin
      w = keyword_text(k);
      if (tok_len >= w.len()) kw_mask[k] = 1'b0;
      else if (w[tok_len] != c) kw_mask[k] = 1'b0;
    end
    tok_len_step();
  endfunction

  function automatic logic [3:0] name_token_kind();
    string w;
    for (int k = 0; k < 3; k++) begin
      w = keyword_text(k);
      if (kw_mask[k] && tok_len == w.len()) return keyword_kind(k);
    end
    return ttok_pkg::KIND_NAME;
  endfunction

  // byte seen with no token in progress
  function automatic void lex_idle_byte(logic [7:0] c);
    lex_go_idle();
    if (is_letter(c)) begin
      mode = PM_WORD;
      name_push_char(c);
    end else if (is_digit(c)) begin
      mode    = PM_DIGITS;
      tok_len = 8'd1;
    end else if (c == CH_QUOTE) begin
      mode    = PM_QUOTED;
      tok_len = 8'd1;
    end else if (c == CH_DASH) begin
      mode = PM_DASH;
    end else begin
      case (c)
        CH_LBRACE:   push_token(ttok_pkg::KIND_LBRACE, 8'd1);
        CH_RBRACE:   push_token(ttok_pkg::KIND_RBRACE, 8'd1);
        CH_LBRACKET: push_token(ttok_pkg::KIND_LBRACKET, 8'd1);
        CH_RBRACKET: push_token(ttok_pkg::KIND_RBRACKET, 8'd1);
        CH_COMMA:    push_token(ttok_pkg::KIND_COMMA, 8'd1);
        CH_SEMI:     push_token(ttok_pkg::KIND_SEMI, 8'd1);
        CH_EQUALS:   push_token(ttok_pkg::KIND_EQUALS, 8'd1);
        default: ;
      endcase
    end
  endfunction

  function automatic void predict_item(logic [7:0] c, logic eoi);
    int n_prior;
    n_prior = expected_tokens.size();
    if (eoi) begin
      // flush a pending name or number, then the end token and a full clear
      if (mode == PM_WORD) push_token(name_token_kind(), tok_len);
      else if (mode == PM_DIGITS) push_token(ttok_pkg::KIND_NUMBER, tok_len);
      push_token(ttok_pkg::KIND_EOF, 8'd0);
      lex_go_idle();
      line_cnt = '0;
    end else begin
      // newline counts first, saturating
      if (c == CH_NEWLINE && line_cnt != 16'hFFFF) line_cnt++;
      case (mode)
        PM_WORD: begin
          if (is_letter(c)) name_push_char(c);
          else begin
            push_token(name_token_kind(), tok_len);
            lex_idle_byte(c);
          end
        end
        PM_DIGITS: begin
          if (is_digit(c)) tok_len_step();
          else begin
            push_token(ttok_pkg::KIND_NUMBER, tok_len);
            lex_idle_byte(c);
          end
        end
        PM_QUOTED: begin
          tok_len_step();
          if (c == CH_QUOTE) begin
            push_token(ttok_pkg::KIND_STRING, tok_len);
            lex_go_idle();
          end
        end
        PM_DASH: begin
          if (c == CH_DASH) mode = PM_COMMENT;
          else lex_idle_byte(c);
        end
        PM_COMMENT: begin
          if (c == CH_NEWLINE) lex_go_idle();
        end
        default: lex_idle_byte(c);
      endcase
    end
    if (expected_tokens.size() > n_prior)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- channels

  // offer one item, wait until accepted, then predict its tokens
  task automatic send_item(input logic [7:0] ch, input logic eoi);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= ch;
    end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(ch, eoi);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // receiver: long hold-off when asked, else random stall bursts
  always @(posedge clk) begin : drive_out_stall
    int stall_left;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted token with the oldest prediction
  always @(posedge clk) begin : check_tokens
    tok_event_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("token with nothing expected: kind %0d line %0d length %0d",
               token_kind, token_line, token_length);
        mismatch_count++;
      end else begin
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (token_kind !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
          mismatch_count++;
        end
        if (token_line !== want.line) begin
          $error("token_line: expected %0d, got %0d", want.line, token_line);
          mismatch_count++;
        end
        if (token_length !== want.length) begin
          $error("token_length: expected %0d, got %0d", want.length, token_length);
          mismatch_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_tokenizer_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_punctuation();
    send_text("{}[],;=");
  endtask

  // keywords ended by a single char and by a newline, name flushed at end
  task automatic test_names_and_keywords();
    send_text("nil;true\nfalse");
    send_eof();
  endtask

  // ignored bytes, number ended by dash, lone dash, comment, string with newline
  task automatic test_numbers_strings_comments();
    send_item(8'hFF, 1'b0);
    send_text("7-x--");
    send_item(8'h00, 1'b0);
    send_text("\n\"\n\"5");
    send_eof();
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    hold_left = 300;
    for (int i = 0; i < 40; i++) send_item((i % 2) ? CH_COMMA : CH_LBRACE, 1'b0);
  endtask

  task automatic send_random_name();
    case ($urandom_range(0, 12))
      0: send_text("true");
      1: send_text("false");
      2: send_text("nil");
      3: send_text("tru");
      4: send_text("fals");
      5: send_text("nill");
      6: send_text("True");
      7: send_text("NIL");
      8: send_text("falsetrue");
      default: begin
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 1)) send_item(8'("a" + $urandom_range(0, 25)), 1'b0);
          else send_item(8'("A" + $urandom_range(0, 25)), 1'b0);
        end
      end
    endcase
  endtask

  // mostly well-formed tokens with random content, plus noise and end marks
  task automatic test_random_text(input int n_items);
    int start;
    logic [7:0] c;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 59) == 0) idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 99)) inside
        [0:14]: send_random_name();
        [15:24]: repeat ($urandom_range(1, 6)) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
        [25:34]: begin
          send_item(CH_QUOTE, 1'b0);
          repeat ($urandom_range(0, 8)) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_QUOTE) c = CH_NEWLINE;
            send_item(c, 1'b0);
          end
          // sometimes left open so an end mark drops it
          if ($urandom_range(0, 9) != 0) send_item(CH_QUOTE, 1'b0);
        end
        [35:54]: begin
          case ($urandom_range(0, 6))
            0: send_item(CH_LBRACE, 1'b0);
            1: send_item(CH_RBRACE, 1'b0);
            2: send_item(CH_LBRACKET, 1'b0);
            3: send_item(CH_RBRACKET, 1'b0);
            4: send_item(CH_COMMA, 1'b0);
            5: send_item(CH_SEMI, 1'b0);
            default: send_item(CH_EQUALS, 1'b0);
          endcase
        end
        [55:69]: begin
          case ($urandom_range(0, 2))
            0: send_item(" ", 1'b0);
            1: send_item(8'h09, 1'b0);
            default: send_item(CH_NEWLINE, 1'b0);
          endcase
        end
        [70:77]: begin
          send_text("--");
          repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_NEWLINE) c = CH_QUOTE;
            send_item(c, 1'b0);
          end
          send_item(CH_NEWLINE, 1'b0);
        end
        [78:81]: send_item(CH_DASH, 1'b0);
        [82:92]: send_item(8'($urandom_range(0, 255)), 1'b0);
        [93:95]: send_eof();
        default: repeat ($urandom_range(2, 4)) send_item(8'($urandom_range(0, 255)), 1'b0);
      endcase
    end
  endtask

  // lengths past 255 saturate
  task automatic test_long_tokens();
    logic [7:0] c;
    send_eof();
    repeat (260) send_item("q", 1'b0);
    send_item(" ", 1'b0);
    repeat (260) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
    send_item(" ", 1'b0);
    send_item(CH_QUOTE, 1'b0);
    repeat (260) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_QUOTE) c = "z";
      send_item(c, 1'b0);
    end
    send_item(CH_QUOTE, 1'b0);
    send_eof();
  endtask

  // line counter follows newlines, then the end mark clears it
  task automatic test_line_count();
    repeat (3) send_item(CH_NEWLINE, 1'b0);
    send_text("abc\n=");
    send_eof();
    send_text("\n;");
    send_eof();
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    lex_go_idle();
    line_cnt = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_punctuation();
    test_names_and_keywords();
    test_numbers_strings_comments();
    test_backpressure();
    test_random_text(800);

    // final part runs without idling
    idle_on = 1'b0;
    test_long_tokens();
    test_line_count();

    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d items and %0d checked tokens", items_sent, tokens_checked);
    $display("including a long receiver hold-off, long tokens and line count clearing");
    if (mismatch_count == 0) begin
      $display("text_tokenizer_tb: clean");
    end else begin
      $display("text_tokenizer_tb: errors");
    end
    $finish;
  end

endmodule
